>>> src/pnef_pkg.sv
// ----------------------------------------------------------------------------
// pnef_pkg
// Shared types and constants of the pure-strategy Nash equilibrium finder.
// ----------------------------------------------------------------------------
package pnef_pkg;

  localparam int MAX_DIM_DEFAULT = 256;
  localparam int DIM_RESET       = 16;
  localparam int CMD_FIFO_DEPTH  = 4;

  // work item classified by the front end
  typedef enum logic [1:0] {
    CMD_LOAD        = 2'd0,
    CMD_FETCH_SCAN  = 2'd1,
    CMD_FETCH_EARLY = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  p1;
    logic [7:0]  p2;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_NONE     = 2'd1,
    ST_NOT_FULL = 2'd2
  } status_e;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_SCAN = 1'b1
  } back_state_e;

endpackage

>>> src/pnef_ram.sv
// ----------------------------------------------------------------------------
// pnef_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pnef_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/pnef_cmd_fifo.sv
// ----------------------------------------------------------------------------
// pnef_cmd_fifo
// Short command queue between front end and back end.
// ----------------------------------------------------------------------------
module pnef_cmd_fifo
  import pnef_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  localparam int PtrW = $clog2(CMD_FIFO_DEPTH);
  localparam int CntW = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t            mem_q [CMD_FIFO_DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(CMD_FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = push ? wptr_q + PtrW'(1) : wptr_q;
    rptr_d = pop ? rptr_q + PtrW'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

>>> src/pnef_front.sv
// ----------------------------------------------------------------------------
// pnef_front
// Accepts requests, counts loaded cells and classifies each request.
// ----------------------------------------------------------------------------
module pnef_front
  import pnef_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT,
  localparam int CntW = $clog2(MAX_DIM * MAX_DIM + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            restart_i,
  input  logic [CntW-1:0] total_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            op_i,
  input  logic [7:0]      p1_i,
  input  logic [7:0]      p2_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output cmd_t            push_data_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            full, is_load;

  assign full    = (cnt_q >= total_i);
  assign is_load = (op_i == 1'b0);

  // loads beyond a full matrix are taken and dropped
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && !(is_load && full);

  always_comb begin
    push_data_o.p1 = p1_i;
    push_data_o.p2 = p2_i;
    if (is_load) begin
      push_data_o.kind = CMD_LOAD;
    end else if (full) begin
      push_data_o.kind = CMD_FETCH_SCAN;
    end else begin
      push_data_o.kind = CMD_FETCH_EARLY;
    end

    cnt_d = cnt_q;
    if (restart_i) begin
      cnt_d = '0;
    end else if (in_valid_i && in_ready_o && is_load && !full) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> src/pnef_back.sv
// ----------------------------------------------------------------------------
// pnef_back
// Executes commands: stores cells, tracks maxima, scans for equilibria.
// ----------------------------------------------------------------------------
module pnef_back
  import pnef_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT,
  localparam int IdxW  = $clog2(MAX_DIM),
  localparam int DimW  = $clog2(MAX_DIM + 1),
  localparam int CntW  = $clog2(MAX_DIM * MAX_DIM + 1),
  localparam int AddrW = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            restart_i,
  input  logic [DimW-1:0] dim_i,
  input  logic [CntW-1:0] total_i,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  cmd_t            cmd_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output status_e         status_o,
  output logic [7:0]      eq_row_o,
  output logic [7:0]      eq_column_o
);

  back_state_e st_q, st_d;

  // load side
  logic [AddrW-1:0]  ld_cnt_q, ld_cnt_d;
  logic [IdxW-1:0]   ld_row_q, ld_row_d, ld_col_q, ld_col_d;
  logic signed [7:0] run_q, run_d, run_new;
  logic              s2l_v_q, s2l_v_d, s2l_first_q, s2l_first_d;
  logic [IdxW-1:0]   s2l_c_q, s2l_c_d;
  logic signed [7:0] s2l_p1_q, s2l_p1_d;
  logic              byp_v_q;
  logic [IdxW-1:0]   byp_c_q;
  logic signed [7:0] byp_val_q, col_old, col_new;

  // scan side
  logic [CntW-1:0]   sc_k_q, sc_k_d;
  logic [IdxW-1:0]   sc_r_q, sc_r_d, sc_c_q, sc_c_d;
  logic [CntW-1:0]   sc_nk;
  logic [IdxW-1:0]   sc_nr, sc_nc;
  logic              s2s_v_q, s2s_v_d;
  logic [IdxW-1:0]   s2s_r_q, s2s_r_d, s2s_c_q, s2s_c_d;
  logic [CntW-1:0]   s2s_nk_q, s2s_nk_d;
  logic [IdxW-1:0]   s2s_nr_q, s2s_nr_d, s2s_nc_q, s2s_nc_d;
  logic              hit;

  // result register
  logic              out_v_q, out_v_d;
  status_e           out_st_q, out_st_d;
  logic [7:0]        out_r_q, out_r_d, out_c_q, out_c_d;

  // memory ports
  logic              pay_we, rmax_we;
  logic [15:0]       pay_rd;
  logic [7:0]        cmax_rd, rmax_rd, rmax_wd;
  logic [IdxW-1:0]   cmax_ra;

  pnef_ram #(.Width(16), .Depth(MAX_DIM * MAX_DIM)) u_payoff_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (ld_cnt_q),
    .wdata_i ({cmd_i.p1, cmd_i.p2}),
    .raddr_i (sc_k_q[AddrW-1:0]),
    .rdata_o (pay_rd)
  );

  pnef_ram #(.Width(8), .Depth(MAX_DIM)) u_colmax_ram (
    .clk_i   (clk_i),
    .we_i    (s2l_v_q),
    .waddr_i (s2l_c_q),
    .wdata_i (col_new),
    .raddr_i (cmax_ra),
    .rdata_o (cmax_rd)
  );

  pnef_ram #(.Width(8), .Depth(MAX_DIM)) u_rowmax_ram (
    .clk_i   (clk_i),
    .we_i    (rmax_we),
    .waddr_i (ld_row_q),
    .wdata_i (rmax_wd),
    .raddr_i (sc_r_q),
    .rdata_o (rmax_rd)
  );

  // column max read-modify-write; bypass the write of the previous cycle
  always_comb begin
    col_old = (byp_v_q && (byp_c_q == s2l_c_q)) ? byp_val_q : $signed(cmax_rd);
    col_new = (s2l_first_q || (s2l_p1_q > col_old)) ? s2l_p1_q : col_old;
  end

  assign run_new = ((ld_col_q == '0) || ($signed(cmd_i.p2) > run_q)) ?
                   $signed(cmd_i.p2) : run_q;
  assign rmax_wd = run_new;
  assign cmax_ra = (st_q == B_SCAN) ? sc_c_q : ld_col_q;

  // next scan position
  always_comb begin
    sc_nk = sc_k_q + CntW'(1);
    if (DimW'(sc_c_q) == dim_i - DimW'(1)) begin
      sc_nc = '0;
      sc_nr = sc_r_q + IdxW'(1);
    end else begin
      sc_nc = sc_c_q + IdxW'(1);
      sc_nr = sc_r_q;
    end
  end

  assign hit = s2s_v_q && (pay_rd[15:8] == cmax_rd) && (pay_rd[7:0] == rmax_rd);

  always_comb begin
    st_d        = st_q;
    cmd_ready_o = 1'b0;
    pay_we      = 1'b0;
    rmax_we     = 1'b0;
    ld_cnt_d    = ld_cnt_q;
    ld_row_d    = ld_row_q;
    ld_col_d    = ld_col_q;
    run_d       = run_q;
    s2l_v_d     = 1'b0;
    s2l_c_d     = ld_col_q;
    s2l_p1_d    = $signed(cmd_i.p1);
    s2l_first_d = (ld_row_q == '0);
    sc_k_d      = sc_k_q;
    sc_r_d      = sc_r_q;
    sc_c_d      = sc_c_q;
    s2s_v_d     = 1'b0;
    s2s_r_d     = sc_r_q;
    s2s_c_d     = sc_c_q;
    s2s_nk_d    = sc_nk;
    s2s_nr_d    = sc_nr;
    s2s_nc_d    = sc_nc;
    out_v_d     = out_v_q && !out_ready_i;
    out_st_d    = out_st_q;
    out_r_d     = out_r_q;
    out_c_d     = out_c_q;

    case (st_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            CMD_LOAD: begin
              cmd_ready_o = 1'b1;
              pay_we      = 1'b1;
              rmax_we     = 1'b1;
              run_d       = run_new;
              s2l_v_d     = 1'b1;
              ld_cnt_d    = ld_cnt_q + AddrW'(1);
              if (DimW'(ld_col_q) == dim_i - DimW'(1)) begin
                ld_col_d = '0;
                ld_row_d = ld_row_q + IdxW'(1);
              end else begin
                ld_col_d = ld_col_q + IdxW'(1);
              end
            end
            CMD_FETCH_EARLY: begin
              if (!out_v_q) begin
                cmd_ready_o = 1'b1;
                out_v_d     = 1'b1;
                out_st_d    = ST_NOT_FULL;
                out_r_d     = '0;
                out_c_d     = '0;
              end
            end
            CMD_FETCH_SCAN: begin
              // result register is empty for the whole scan
              if (!out_v_q) begin
                cmd_ready_o = 1'b1;
                st_d        = B_SCAN;
              end
            end
            default: begin
              cmd_ready_o = 1'b1;
            end
          endcase
        end
      end
      B_SCAN: begin
        if (hit) begin
          // drop the read issued behind the hit, resume after the hit
          out_v_d  = 1'b1;
          out_st_d = ST_FOUND;
          out_r_d  = 8'(s2s_r_q);
          out_c_d  = 8'(s2s_c_q);
          sc_k_d   = s2s_nk_q;
          sc_r_d   = s2s_nr_q;
          sc_c_d   = s2s_nc_q;
          st_d     = B_IDLE;
        end else if (sc_k_q < total_i) begin
          s2s_v_d = 1'b1;
          sc_k_d  = sc_nk;
          sc_r_d  = sc_nr;
          sc_c_d  = sc_nc;
        end else if (!s2s_v_q) begin
          out_v_d  = 1'b1;
          out_st_d = ST_NONE;
          out_r_d  = '0;
          out_c_d  = '0;
          st_d     = B_IDLE;
        end
      end
      default: begin
        st_d = B_IDLE;
      end
    endcase

    if (restart_i) begin
      ld_cnt_d = '0;
      ld_row_d = '0;
      ld_col_d = '0;
      run_d    = -8'sd128;
      sc_k_d   = '0;
      sc_r_d   = '0;
      sc_c_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= B_IDLE;
      ld_cnt_q <= '0;
      ld_row_q <= '0;
      ld_col_q <= '0;
      run_q    <= -8'sd128;
      s2l_v_q  <= 1'b0;
      byp_v_q  <= 1'b0;
      sc_k_q   <= '0;
      sc_r_q   <= '0;
      sc_c_q   <= '0;
      s2s_v_q  <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      st_q     <= st_d;
      ld_cnt_q <= ld_cnt_d;
      ld_row_q <= ld_row_d;
      ld_col_q <= ld_col_d;
      run_q    <= run_d;
      s2l_v_q  <= s2l_v_d;
      byp_v_q  <= s2l_v_q;
      sc_k_q   <= sc_k_d;
      sc_r_q   <= sc_r_d;
      sc_c_q   <= sc_c_d;
      s2s_v_q  <= s2s_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s2l_c_q     <= s2l_c_d;
    s2l_p1_q    <= s2l_p1_d;
    s2l_first_q <= s2l_first_d;
    byp_c_q     <= s2l_c_q;
    byp_val_q   <= col_new;
    s2s_r_q     <= s2s_r_d;
    s2s_c_q     <= s2s_c_d;
    s2s_nk_q    <= s2s_nk_d;
    s2s_nr_q    <= s2s_nr_d;
    s2s_nc_q    <= s2s_nc_d;
    out_st_q    <= out_st_d;
    out_r_q     <= out_r_d;
    out_c_q     <= out_c_d;
  end

  assign out_valid_o = out_v_q;
  assign status_o    = out_st_q;
  assign eq_row_o    = out_r_q;
  assign eq_column_o = out_c_q;

endmodule

>>> src/pure_nash_equilibrium_finder_unit.sv
// ----------------------------------------------------------------------------
// pure_nash_equilibrium_finder_unit
// Pure-strategy Nash equilibrium finder for a square two-player game.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o): op_i = 0 loads the next cell
//   (both players' signed payoffs) in row-major order; op_i = 1 fetches the
//   next equilibrium. Each fetch request yields one result on the output
//   channel (out_valid_o/out_ready_i); loads yield none.
//   cfg_we_i writes the side length (0 acts as 1, above MAX_DIM as MAX_DIM)
//   and restarts loading and the scan.
//   Loads are stored at one per cycle while the back end is idle and no
//   fetch waits at the queue head, limited by the single write port of the
//   payoff RAM. A fetch before the matrix is full is answered with status
//   not-full. A scanning fetch examines one cell per cycle through the
//   payoff and maxima RAM read ports. Requests are taken into a 4-entry
//   command queue, so loads keep flowing while a result waits in the output
//   register; a fetch waits at the queue head until that register is empty.
//   Reset: side length 16, nothing loaded, scan at the first cell.
// ----------------------------------------------------------------------------
module pure_nash_equilibrium_finder_unit
  import pnef_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [8:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic signed [7:0] payoff_row_player_i,
  input  logic signed [7:0] payoff_col_player_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [7:0]        eq_row_o,
  output logic [7:0]        eq_column_o
);

  localparam int DimW   = $clog2(MAX_DIM + 1);
  localparam int CntW   = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int DimRst = (MAX_DIM < DIM_RESET) ? MAX_DIM : DIM_RESET;

  // effective side length and cell count, held as registers
  logic [DimW-1:0]   dim_q, dim_d;
  logic [CntW-1:0]   total_q, total_d;
  logic [2*DimW-1:0] prod;

  cmd_t    push_data, pop_data;
  logic    push_valid, push_ready, pop_valid, pop_ready;
  status_e status;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      dim_d = DimW'(1);
    end else if (32'(cfg_wdata_i) > 32'(MAX_DIM)) begin
      dim_d = DimW'(MAX_DIM);
    end else begin
      dim_d = DimW'(cfg_wdata_i);
    end
    prod    = dim_d * dim_d;
    total_d = CntW'(prod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q   <= DimW'(DimRst);
      total_q <= CntW'(DimRst * DimRst);
    end else if (cfg_we_i) begin
      dim_q   <= dim_d;
      total_q <= total_d;
    end
  end

  // front: take requests, classify against the loaded-cell count
  pnef_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (cfg_we_i),
    .total_i      (total_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .p1_i         (payoff_row_player_i),
    .p2_i         (payoff_col_player_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  pnef_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // back: storage, maxima and equilibrium scan
  pnef_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_we_i),
    .dim_i       (dim_q),
    .total_i     (total_q),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status),
    .eq_row_o    (eq_row_o),
    .eq_column_o (eq_column_o)
  );

  assign status_o = status;

endmodule
